FILE: rtl/wheel_six_prime_sieve_unit_assert.svh
// assertion macros for the wheel-six prime sieve unit
// depends on a clock named i_clk and an active-low reset named i_rst_n in the using scope
`ifndef WHEEL_SIX_PRIME_SIEVE_UNIT_ASSERT_SVH
`define WHEEL_SIX_PRIME_SIEVE_UNIT_ASSERT_SVH

// same-cycle implication
`define WSPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wsps_pkg.sv
// shared types and constants of the wheel-six prime sieve unit
// no dependencies
package wsps_pkg;

    localparam int NUM_W    = 16;
    localparam int LIMIT_W  = 17;
    localparam int COUNT_W  = 17;

    localparam int                 DEF_TABLE_DEPTH = 65536;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 17'h10000;

    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NOT_BUILT = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_P_TEST,
        S_P_WAIT,
        S_STRIKE,
        S_CNT,
        S_DRAIN,
        S_Q_READ,
        S_Q_DATA,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic start_build;
        logic fill_step;
        logic p_init;
        logic p_read;
        logic strike_init;
        logic strike_step;
        logic p_next;
        logic cnt_init;
        logic cnt_step;
        logic finish_build;
        logic q_latch;
        logic q_read;
        logic q_result;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic n_done;
        logic p_done;
        logic p_cand;
        logic j_done;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/wsps_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wsps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/wsps_ctrl.sv
// sequencer of the wheel-six prime sieve: build passes, queries, result hand-off
// depends on wsps_pkg
module wsps_ctrl
    import wsps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_op == OP_BUILD) begin
                        o_cmd.start_build = 1'b1;
                        n_state = S_FILL;
                    end else begin
                        o_cmd.q_latch = 1'b1;
                        n_state = S_Q_READ;
                    end
                end
            end
            S_FILL: begin
                if (i_sts.n_done) begin
                    o_cmd.p_init = 1'b1;
                    n_state = S_P_TEST;
                end else begin
                    o_cmd.fill_step = 1'b1;
                end
            end
            S_P_TEST: begin
                if (i_sts.p_done) begin
                    o_cmd.cnt_init = 1'b1;
                    n_state = S_CNT;
                end else begin
                    o_cmd.p_read = 1'b1;
                    n_state = S_P_WAIT;
                end
            end
            S_P_WAIT: begin
                if (i_sts.p_cand) begin
                    o_cmd.strike_init = 1'b1;
                    n_state = S_STRIKE;
                end else begin
                    o_cmd.p_next = 1'b1;
                    n_state = S_P_TEST;
                end
            end
            S_STRIKE: begin
                if (i_sts.j_done) begin
                    o_cmd.p_next = 1'b1;
                    n_state = S_P_TEST;
                end else begin
                    o_cmd.strike_step = 1'b1;
                end
            end
            S_CNT: begin
                if (i_sts.n_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_DRAIN: begin
                o_cmd.finish_build = 1'b1;
                n_state = S_RESULT;
            end
            S_Q_READ: begin
                o_cmd.q_read = 1'b1;
                n_state = S_Q_DATA;
            end
            S_Q_DATA: begin
                o_cmd.q_result = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/wsps_dp.sv
// datapath of the wheel-six prime sieve: counters, prime table, result registers
// depends on wsps_pkg and wsps_ram
module wsps_dp
    import wsps_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [LIMIT_W-1:0] i_cfg_sieve_limit,
    input  logic [NUM_W-1:0]   i_number,
    input  logic               i_out_stall,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic               o_is_prime,
    output t_status            o_status,
    output logic [COUNT_W-1:0] o_prime_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = (AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W;
    localparam int SW = LW + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

    logic [LIMIT_W-1:0] r_limit;
    logic [LW-1:0]      r_lim;
    logic [LW-1:0]      r_n;
    logic [2:0]         r_mod6;
    logic [LW-1:0]      r_p;
    logic [2:0]         r_pmod6;
    logic [SW-1:0]      r_psq;
    logic [SW-1:0]      r_j;
    logic               r_phase;
    logic               r_rd_vld;
    logic [COUNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]   r_num;
    logic               r_built;
    logic [LW-1:0]      r_built_lim;
    logic [COUNT_W-1:0] r_primes;
    logic               r_res_prime;
    t_status            r_res_status;
    logic               r_out_valid;
    logic               r_out_prime;
    t_status            r_out_status;
    logic [COUNT_W-1:0] r_out_count;

    logic [LW-1:0] w_lim_cfg;
    logic [LW-1:0] w_num_ext;
    logic [SW-1:0] w_p_ext;
    logic [SW-1:0] w_p2;
    logic [SW-1:0] w_p4;
    logic [SW-1:0] w_step;
    logic          w_fill_bit;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [0:0]    w_wdata;
    logic [AW-1:0] w_raddr;
    logic [0:0]    w_rdata;

    assign w_lim_cfg = LW'(r_limit);
    assign w_num_ext = LW'(r_num);
    assign w_p_ext   = SW'(r_p);
    assign w_p2      = w_p_ext << 1;
    assign w_p4      = w_p_ext << 2;
    // p*p is 1 mod 6; for p = 5 mod 6 the next wheel multiple is 2p ahead
    assign w_step    = ((r_pmod6 == 3'd5) ^ r_phase) ? w_p2 : w_p4;

    // wheel pattern: 2, 3 and every 6k+-1 from 5 upward
    assign w_fill_bit = (r_n == LW'(2)) || (r_n == LW'(3)) ||
                        ((r_n >= LW'(5)) && ((r_mod6 == 3'd1) || (r_mod6 == 3'd5)));

    assign w_we    = i_cmd.fill_step | i_cmd.strike_step;
    assign w_waddr = i_cmd.strike_step ? r_j[AW-1:0] : r_n[AW-1:0];
    assign w_wdata = i_cmd.strike_step ? 1'b0 : w_fill_bit;

    always_comb begin
        if (i_cmd.p_read) begin
            w_raddr = r_p[AW-1:0];
        end else if (i_cmd.q_read) begin
            w_raddr = w_num_ext[AW-1:0];
        end else begin
            w_raddr = r_n[AW-1:0];
        end
    end

    wsps_ram #(
        .WIDTH(1),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_RESET;
            r_built     <= 1'b0;
            r_built_lim <= '0;
            r_primes    <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_sieve_limit;
            end
            if (i_cmd.finish_build) begin
                r_built     <= 1'b1;
                r_built_lim <= r_lim;
                r_primes    <= r_cnt;
            end
            r_rd_vld <= i_cmd.cnt_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk counters and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_build) begin
            r_lim  <= (w_lim_cfg > DEPTH_L) ? DEPTH_L : w_lim_cfg;
            r_n    <= '0;
            r_mod6 <= '0;
        end else if (i_cmd.fill_step) begin
            r_n    <= r_n + LW'(1);
            r_mod6 <= (r_mod6 == 3'd5) ? 3'd0 : r_mod6 + 3'd1;
        end else if (i_cmd.cnt_init) begin
            r_n <= LW'(5);
        end else if (i_cmd.cnt_step) begin
            r_n <= r_n + LW'(1);
        end

        if (i_cmd.p_init) begin
            r_p     <= LW'(5);
            r_pmod6 <= 3'd5;
            r_psq   <= SW'(25);
        end else if (i_cmd.p_next) begin
            r_p     <= r_p + LW'(1);
            r_pmod6 <= (r_pmod6 == 3'd5) ? 3'd0 : r_pmod6 + 3'd1;
            // (p+1)^2 = p^2 + 2p + 1
            r_psq   <= r_psq + {r_p, 1'b1};
        end

        if (i_cmd.strike_init) begin
            r_j     <= r_psq;
            r_phase <= 1'b0;
        end else if (i_cmd.strike_step) begin
            r_j     <= r_j + w_step;
            r_phase <= ~r_phase;
        end

        if (i_cmd.cnt_init) begin
            r_cnt <= '0;
        end else if (r_rd_vld) begin
            r_cnt <= r_cnt + COUNT_W'(w_rdata);
        end

        if (i_cmd.q_latch) begin
            r_num <= i_number;
        end

        if (i_cmd.finish_build) begin
            r_res_prime  <= 1'b0;
            r_res_status <= ST_OK;
        end else if (i_cmd.q_result) begin
            if (!r_built) begin
                r_res_prime  <= 1'b0;
                r_res_status <= ST_NOT_BUILT;
            end else if (w_num_ext >= r_built_lim) begin
                r_res_prime  <= 1'b0;
                r_res_status <= ST_RANGE;
            end else begin
                r_res_prime  <= w_rdata[0];
                r_res_status <= ST_OK;
            end
        end

        if (i_cmd.out_load) begin
            r_out_prime  <= r_res_prime;
            r_out_status <= r_res_status;
            r_out_count  <= r_primes;
        end
    end

    assign o_sts.n_done   = (r_n >= r_lim);
    assign o_sts.p_done   = (r_psq >= SW'(r_lim));
    assign o_sts.p_cand   = w_rdata[0];
    assign o_sts.j_done   = (r_j >= SW'(r_lim));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_is_prime    = r_out_prime;
    assign o_status      = r_out_status;
    assign o_prime_count = r_out_count;

endmodule

FILE: rtl/wheel_six_prime_sieve_unit.sv
// query: latched, table read, result loaded when the output is free, then back to idle
// build: wheel fill, then for each p with p*p < L a test and a read, for each surviving p
//   a strike walk, then a count pass from 5 and the output; L = min(limit, table depth)
// reset: synchronous; control, built flag and count cleared, limit register set to 65536;
//   the table holds no valid bits and stays undefined until the first build
// top level of the wheel-six prime sieve unit; depends on wsps_pkg, wsps_ctrl, wsps_dp
`include "wheel_six_prime_sieve_unit_assert.svh"
module wheel_six_prime_sieve_unit
    import wsps_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write channel, always ready
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LIMIT_W-1:0] i_cfg_sieve_limit,
    // input transaction channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [NUM_W-1:0]   i_number,
    // result transaction channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_is_prime,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_prime_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_status w_status;

    // limit register takes a write in any cycle; it is latched at build start
    assign o_cfg_ready = 1'b1;

    // sequencer: accepts a transaction only when idle, holds the result
    // in a wait state until the output register is free
    wsps_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_op      (i_op),
        .o_in_stall(o_in_stall),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // datapath: wheel fill, strike walk, count pass, query read, output register
    wsps_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_sieve_limit(i_cfg_sieve_limit),
        .i_number         (i_number),
        .i_out_stall      (i_out_stall),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_out_valid      (o_out_valid),
        .o_is_prime       (o_is_prime),
        .o_status         (w_status),
        .o_prime_count    (o_prime_count)
    );

    assign o_status = w_status;

    // one transaction in flight: an accept is followed by stall
    `WSPS_ASSERT_NEXT(a_single_inflight, i_in_valid && !o_in_stall, o_in_stall, "busy accept")
    // output register never overwritten while a result waits under stall
    `WSPS_ASSERT_NOW(a_load_when_free, w_cmd.out_load, !o_out_valid || !i_out_stall, "overwrite")
    // strikes only land below the latched limit
    `WSPS_ASSERT_NOW(a_strike_in_range, w_cmd.strike_step, !w_sts.j_done, "strike beyond limit")
    // a prime answer only comes with an ok status
    `WSPS_ASSERT_NOW(a_prime_status_ok, o_out_valid && o_is_prime, o_status == ST_OK, "bad status")

endmodule

FILE: bench/tb_top.sv
// self-checking testbench for wheel_six_prime_sieve_unit: directed table, then random phases
// depends on wsps_pkg and the rtl of the unit; keeps its own prime table to predict results
module tb_top
    import wsps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH   = DEF_TABLE_DEPTH;
    localparam int N_PHASES    = 14;
    localparam int PRESS_PHASE = 4;
    localparam int PRESS_ITEMS = 24;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 16;
    localparam int CYCLE_LIMIT = 12000000;

    typedef struct packed {
        logic                is_prime;
        t_status             status;
        logic [COUNT_W-1:0]  prime_count;
    } t_sieve_result;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        logic                op;
        logic [NUM_W-1:0]    number;
        logic [LIMIT_W-1:0]  limit;
        bit                  typed;
        logic                w_prime;
        t_status             w_status;
        logic [COUNT_W-1:0]  w_count;
    } t_dir_row;

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_cfg_valid       = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_sieve_limit = '0;
    logic               i_in_valid        = 1'b0;
    logic               i_op              = OP_QUERY;
    logic [NUM_W-1:0]   i_number          = '0;
    logic               i_out_stall       = 1'b0;
    logic               o_cfg_ready;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               o_is_prime;
    logic [1:0]         o_status;
    logic [COUNT_W-1:0] o_prime_count;

    // shadow of the unit: limit register, prime table, latched limit, count
    logic [LIMIT_W-1:0] limit_reg     = LIMIT_RESET;
    bit                 prime_tab [TBL_DEPTH];
    bit                 table_ready   = 1'b0;
    int unsigned        latched_limit = 0;
    logic [COUNT_W-1:0] found_count   = '0;

    t_sieve_result      pending [$];
    t_sieve_result      want_res;
    t_sieve_result      blank_res     = '0;
    int                 n_errors      = 0;
    bit                 idling_on     = 1'b1;
    bit                 hold_req      = 1'b0;
    int                 hold_cnt;
    int                 cyc;

    // directed rows: typed expectations only where they are obvious
    t_dir_row dir_rows [$] = '{
        // queries before any build are refused
        '{ROW_ITEM, OP_QUERY, 16'd7,     17'd0,      1'b1, 1'b0, ST_NOT_BUILT, 17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd65535, 17'd0,      1'b1, 1'b0, ST_NOT_BUILT, 17'd0},
        // full table with the limit left at its reset value
        '{ROW_ITEM, OP_BUILD, 16'd0,     17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd0,     17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd1,     17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd2,     17'd0,      1'b1, 1'b1, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd3,     17'd0,      1'b1, 1'b1, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd4,     17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd25,    17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd65521, 17'd0,      1'b1, 1'b1, ST_OK,        17'd6540},
        '{ROW_ITEM, OP_QUERY, 16'd65535, 17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        // limit above the table depth clamps; queries keep the old latch until rebuilt
        '{ROW_CFG,  OP_QUERY, 16'd0,     17'd131071, 1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd40000, 17'd0,      1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_BUILD, 16'd65535, 17'd0,      1'b1, 1'b0, ST_OK,        17'd6540},
        // limit of 8: the count holds only 5 and 7
        '{ROW_CFG,  OP_QUERY, 16'd0,     17'd8,      1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd65535, 17'd0,      1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_BUILD, 16'd0,     17'd0,      1'b1, 1'b0, ST_OK,        17'd2},
        '{ROW_ITEM, OP_QUERY, 16'd7,     17'd0,      1'b1, 1'b1, ST_OK,        17'd2},
        '{ROW_ITEM, OP_QUERY, 16'd8,     17'd0,      1'b1, 1'b0, ST_RANGE,     17'd2},
        // limits below the sieved range
        '{ROW_CFG,  OP_QUERY, 16'd0,     17'd5,      1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_BUILD, 16'd0,     17'd0,      1'b1, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd4,     17'd0,      1'b1, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd5,     17'd0,      1'b1, 1'b0, ST_RANGE,     17'd0},
        '{ROW_CFG,  OP_QUERY, 16'd0,     17'd0,      1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_BUILD, 16'd0,     17'd0,      1'b1, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd0,     17'd0,      1'b1, 1'b0, ST_RANGE,     17'd0},
        // 49 is struck only when 7*7 lies below the limit
        '{ROW_CFG,  OP_QUERY, 16'd0,     17'd50,     1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_BUILD, 16'd0,     17'd0,      1'b0, 1'b0, ST_OK,        17'd0},
        '{ROW_ITEM, OP_QUERY, 16'd49,    17'd0,      1'b1, 1'b0, ST_OK,        17'd13},
        '{ROW_ITEM, OP_QUERY, 16'd47,    17'd0,      1'b0, 1'b0, ST_OK,        17'd0}
    };

    wheel_six_prime_sieve_unit #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_sieve_limit (i_cfg_sieve_limit),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_number          (i_number),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_is_prime        (o_is_prime),
        .o_status          (o_status),
        .o_prime_count     (o_prime_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // wheel fill, then strike from p*p with alternating 2p / 4p steps, then count from 5
    function automatic void rebuild_table(int unsigned lim);
        int unsigned     n;
        int unsigned     tally;
        longint unsigned p, j, step_a, step_b;
        tally = 0;
        for (n = 0; n < lim; n++)
            prime_tab[n] = (n == 2 || n == 3 || (n >= 5 && (n % 6 == 1 || n % 6 == 5)));
        for (p = 5; p * p < lim; p++) begin
            if (!prime_tab[p])
                continue;
            if (p % 6 == 5) begin
                step_a = 2 * p;
                step_b = 4 * p;
            end else begin
                step_a = 4 * p;
                step_b = 2 * p;
            end
            j = p * p;
            while (j < lim) begin
                prime_tab[j] = 1'b0;
                j += step_a;
                if (j >= lim)
                    break;
                prime_tab[j] = 1'b0;
                j += step_b;
            end
        end
        for (n = 5; n < lim; n++)
            if (prime_tab[n])
                tally++;
        found_count   = tally[COUNT_W-1:0];
        latched_limit = lim;
        table_ready   = 1'b1;
    endfunction

    function automatic t_sieve_result predict_item(logic op, logic [NUM_W-1:0] num);
        t_sieve_result res;
        int unsigned   lim;
        res = '{1'b0, ST_OK, '0};
        if (op == OP_BUILD) begin
            lim = (limit_reg > TBL_DEPTH) ? TBL_DEPTH : limit_reg;
            rebuild_table(lim);
        end else if (!table_ready) begin
            res.status = ST_NOT_BUILT;
        end else if (num >= latched_limit) begin
            res.status = ST_RANGE;
        end else begin
            res.is_prime = prime_tab[num];
        end
        res.prime_count = found_count;
        return res;
    endfunction

    // mostly small tables so builds stay short
    function automatic logic [LIMIT_W-1:0] pick_limit();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return LIMIT_W'($urandom_range(0, 7));
        if (roll < 75)
            return LIMIT_W'($urandom_range(8, 1024));
        if (roll < 95)
            return LIMIT_W'($urandom_range(1025, 8192));
        return LIMIT_W'($urandom_range(8193, 20000));
    endfunction

    // inside the table, around its edge, or anywhere
    function automatic logic [NUM_W-1:0] pick_number();
        int roll;
        int near;
        roll = $urandom_range(0, 99);
        if (!table_ready || roll >= 85)
            return NUM_W'($urandom_range(0, 65535));
        if (roll < 70 && latched_limit > 0)
            return NUM_W'($urandom_range(0, latched_limit - 1));
        near = int'(latched_limit) + int'($urandom_range(0, 3)) - 1;
        if (near < 0)
            near = 0;
        if (near > 65535)
            near = 65535;
        return near[NUM_W-1:0];
    endfunction

    // offer one transaction, hold it until taken, then record what it should return
    task automatic send_item(logic op, logic [NUM_W-1:0] num, bit typed,
                             t_sieve_result typed_res);
        t_sieve_result guess;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_number   <= num;
        do @(posedge i_clk); while (o_in_stall);
        guess = predict_item(op, num);
        pending.push_back(typed ? typed_res : guess);
    endtask

    // every transaction yields a result, so an empty queue means the unit is idle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] val);
        i_cfg_valid       <= 1'b1;
        i_cfg_sieve_limit <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        limit_reg = val;
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // result checker: oldest expectation against each accepted result transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result is_prime %0b status %0d count %0d",
                         $time, o_is_prime, o_status, o_prime_count);
                n_errors++;
            end else begin
                want_res = pending.pop_front();
                if (o_is_prime !== want_res.is_prime) begin
                    $display("%0t: is_prime expected %0b got %0b",
                             $time, want_res.is_prime, o_is_prime);
                    n_errors++;
                end
                if (o_status !== want_res.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want_res.status, o_status);
                    n_errors++;
                end
                if (o_prime_count !== want_res.prime_count) begin
                    $display("%0t: prime_count expected %0d got %0d",
                             $time, want_res.prime_count, o_prime_count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int            ph, k, n_items, pre_q;
        t_dir_row      row;
        t_sieve_result row_res;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (k = 0; k < dir_rows.size(); k++) begin
            row = dir_rows[k];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_limit(row.limit);
            end else begin
                row_res = '{row.w_prime, row.w_status, row.w_count};
                send_item(row.op, row.number, row.typed, row_res);
            end
        end

        // random phases: new limit, a few queries on the old latch, a build, then mostly queries
        for (ph = 0; ph < N_PHASES; ph++) begin
            idling_on = (ph < N_PHASES - 2) && ($urandom_range(0, 3) != 0);
            if (ph == PRESS_PHASE) begin
                // back-to-back queries into a receiver that holds off
                idling_on = 1'b0;
                hold_req  = 1'b1;
                for (k = 0; k < PRESS_ITEMS; k++)
                    send_item(OP_QUERY, pick_number(), 1'b0, blank_res);
            end else begin
                wait_idle();
                write_limit(pick_limit());
                n_items = $urandom_range(28, 36);
                pre_q   = $urandom_range(0, 3);
                for (k = 0; k < n_items; k++) begin
                    if (k == pre_q || (k > pre_q && $urandom_range(0, 99) < 8))
                        send_item(OP_BUILD, NUM_W'($urandom_range(0, 65535)), 1'b0, blank_res);
                    else
                        send_item(OP_QUERY, pick_number(), 1'b0, blank_res);
                end
            end
        end

        // drain and let any stray result show up
        idling_on = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: wheel_six_prime_sieve_unit.f
+incdir+rtl
rtl/wsps_pkg.sv
rtl/wsps_ram.sv
rtl/wsps_ctrl.sv
rtl/wsps_dp.sv
rtl/wheel_six_prime_sieve_unit.sv
bench/tb_top.sv
